// ----- design/i2cst_pkg.sv -----
// Shared types, constants and helpers for the I2C SCL timing calculator.
package i2cst_pkg;

  // Field widths
  localparam int PCLK_W  = 26;
  localparam int SPEED_W = 20;
  localparam int ADDR_W  = 8;
  localparam int MHZ_W   = 6;
  localparam int DVSR_W  = 24;
  localparam int QUO_W   = PCLK_W;

  // Divider shape: quotient bits resolved per stage and stage count
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = QUO_W / DIV_BPS;
  localparam int FRONT_LAT  = 2;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  // Limits
  localparam logic [PCLK_W-1:0]  PCLK_MIN_HZ = 26'd2000000;
  localparam logic [PCLK_W-1:0]  PCLK_MAX_HZ = 26'd50000000;
  localparam logic [SPEED_W-1:0] STD_MAX_HZ  = 20'd100000;
  localparam logic [SPEED_W-1:0] FAST_MAX_HZ = 20'd400000;
  localparam logic [ADDR_W-1:0]  ADDR_MAX    = 8'd127;

  // Hz to MHz: 1e6 = 64 * 15625, x/15625 estimated as (x * 67) >> 20, low by at most one
  localparam int               MHZ_LO_SHIFT = 6;
  localparam int               X_W          = PCLK_W - MHZ_LO_SHIFT;
  localparam int               RECIP_W      = 7;
  localparam int               PROD_W       = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MHZ_RECIP  = 7'd67;
  localparam logic [X_W:0]     MHZ_DIV_LO   = 21'd15625;

  typedef struct packed {
    logic [PCLK_W-1:0]  pclk_hz;
    logic [SPEED_W-1:0] speed_hz;
    logic               duty_mode;
    logic [ADDR_W-1:0]  self_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] ccr_value;
    logic        fast_mode;
    logic        duty_flag;
    logic [5:0]  rise_value;
    logic [5:0]  freq_mhz;
    logic [14:0] addr_reg_value;
  } rsp_t;

  // Per-item side information carried alongside the divider
  typedef struct packed {
    logic [1:0]       status;
    logic             fast;
    logic             dflag;
    logic [MHZ_W-1:0] mhz;
    logic [6:0]       addr;
  } meta_t;

  typedef struct packed {
    logic [PCLK_W-1:0] pclk;
    logic [DVSR_W-1:0] dvsr;
    meta_t             meta;
  } div_in_t;

  // Fast mode rise time: mhz*3/10 + 1, with /10 as (x*205) >> 11 for x below 1029
  function automatic logic [7:0] rise_fast(input logic [MHZ_W-1:0] mhz);
    logic [7:0]  x3;
    logic [15:0] p;
    x3 = {2'b0, mhz} + {1'b0, mhz, 1'b0};
    p  = {8'b0, x3} * 16'd205;
    return {3'b0, p[15:11]} + 8'd1;
  endfunction

endpackage

// ----- design/i2cst_front.sv -----
// Front end: parameter checks, Hz to MHz conversion and divisor selection.
module i2cst_front import i2cst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  req_t    req,
  output logic    out_valid,
  output div_in_t div_in
);

  // Stage A registers
  logic              a_valid;
  logic              a_inv;
  logic              a_range_ok;
  logic              a_low_zero;
  logic              a_fast;
  logic              a_dflag;
  logic [X_W-1:0]    a_x;
  logic [PROD_W-1:0] a_prod;
  logic [PCLK_W-1:0] a_pclk;
  logic [DVSR_W-1:0] a_dvsr;
  logic [6:0]        a_addr;

  logic              inv;
  logic              fast;
  logic [DVSR_W-1:0] s24;
  logic [DVSR_W-1:0] dvsr;
  logic [X_W-1:0]    x;

  // Check the request and pick the divisor
  always_comb begin
    inv  = (req.speed_hz == '0) || (req.speed_hz > FAST_MAX_HZ) ||
           (req.self_addr > ADDR_MAX);
    fast = req.speed_hz > STD_MAX_HZ;
    s24  = {{(DVSR_W-SPEED_W){1'b0}}, req.speed_hz};
    if (!fast) begin
      dvsr = s24 << 1;
    end else if (req.duty_mode) begin
      dvsr = (s24 << 4) + (s24 << 3) + s24;
    end else begin
      dvsr = (s24 << 1) + s24;
    end
    x = req.pclk_hz[PCLK_W-1:MHZ_LO_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_inv      <= inv;
    a_range_ok <= (req.pclk_hz >= PCLK_MIN_HZ) && (req.pclk_hz <= PCLK_MAX_HZ);
    a_low_zero <= req.pclk_hz[MHZ_LO_SHIFT-1:0] == '0;
    a_fast     <= fast;
    a_dflag    <= fast && req.duty_mode;
    a_x        <= x;
    a_prod     <= {{RECIP_W{1'b0}}, x} * {{X_W{1'b0}}, MHZ_RECIP};
    a_pclk     <= req.pclk_hz;
    a_dvsr     <= dvsr;
    a_addr     <= req.self_addr[6:0];
  end

  logic [RECIP_W-1:0] q0;
  logic [X_W:0]       r_raw;
  logic               r_hi;
  logic [X_W:0]       r_fin;
  logic [RECIP_W-1:0] mhz_full;
  logic               whole;
  meta_t              meta_next;

  // Correct the MHz estimate by one and test for a whole number of MHz
  always_comb begin
    q0       = a_prod[PROD_W-1:X_W];
    r_raw    = {1'b0, a_x} - ({{(X_W+1-RECIP_W){1'b0}}, q0} * MHZ_DIV_LO);
    r_hi     = r_raw >= MHZ_DIV_LO;
    r_fin    = r_hi ? r_raw - MHZ_DIV_LO : r_raw;
    mhz_full = q0 + {{(RECIP_W-1){1'b0}}, r_hi};
    whole    = (r_fin == '0) && a_low_zero;

    meta_next.fast  = a_fast;
    meta_next.dflag = a_dflag;
    meta_next.mhz   = mhz_full[MHZ_W-1:0];
    meta_next.addr  = a_addr;
    priority if (a_inv) begin
      meta_next.status = ST_INVALID;
    end else if (!a_range_ok || !whole) begin
      meta_next.status = ST_UNSUPPORTED;
    end else begin
      meta_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
    div_in.pclk <= a_pclk;
    div_in.dvsr <= a_dvsr;
    div_in.meta <= meta_next;
  end

endmodule

// ----- design/i2cst_div.sv -----
// Pipelined restoring divider: pclk over divisor, two quotient bits per stage.
module i2cst_div import i2cst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  div_in_t          in_item,
  output logic             out_valid,
  output logic [QUO_W-1:0] quo,
  output meta_t            meta
);

  logic [DIV_STAGES-1:0] vld;
  logic [DVSR_W-1:0]     rem_q      [DIV_STAGES];
  logic [PCLK_W-1:0]     num_q      [DIV_STAGES];
  logic [QUO_W-1:0]      quo_q      [DIV_STAGES];
  logic [DVSR_W-1:0]     dv_q       [DIV_STAGES];
  meta_t                 meta_q     [DIV_STAGES];
  logic [DVSR_W-1:0]     rem_next   [DIV_STAGES];
  logic [PCLK_W-1:0]     num_next   [DIV_STAGES];
  logic [QUO_W-1:0]      quo_next   [DIV_STAGES];
  logic [DVSR_W-1:0]     dv_in      [DIV_STAGES];
  meta_t                 meta_in    [DIV_STAGES];
  logic [DVSR_W-1:0]     rem_in     [DIV_STAGES];
  logic [PCLK_W-1:0]     num_in     [DIV_STAGES];
  logic [QUO_W-1:0]      quo_in     [DIV_STAGES];

  // Feed each stage from the one before it
  always_comb begin
    rem_in[0]  = '0;
    num_in[0]  = in_item.pclk;
    quo_in[0]  = '0;
    dv_in[0]   = in_item.dvsr;
    meta_in[0] = in_item.meta;
    for (int s = 1; s < DIV_STAGES; s++) begin
      rem_in[s]  = rem_q[s-1];
      num_in[s]  = num_q[s-1];
      quo_in[s]  = quo_q[s-1];
      dv_in[s]   = dv_q[s-1];
      meta_in[s] = meta_q[s-1];
    end
  end

  // Shift in a dividend bit, subtract the divisor where it fits
  always_comb begin : step
    logic [DVSR_W:0]   t;
    logic [DVSR_W-1:0] r;
    logic [PCLK_W-1:0] n;
    logic [QUO_W-1:0]  q;
    for (int s = 0; s < DIV_STAGES; s++) begin
      r = rem_in[s];
      n = num_in[s];
      q = quo_in[s];
      for (int b = 0; b < DIV_BPS; b++) begin
        t = {r, n[PCLK_W-1]};
        n = {n[PCLK_W-2:0], 1'b0};
        if (t >= {1'b0, dv_in[s]}) begin
          r = DVSR_W'(t - {1'b0, dv_in[s]});
          q = {q[QUO_W-2:0], 1'b1};
        end else begin
          r = t[DVSR_W-1:0];
          q = {q[QUO_W-2:0], 1'b0};
        end
      end
      rem_next[s] = r;
      num_next[s] = n;
      quo_next[s] = q;
    end
  end

  // Advance all stages every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIV_STAGES-2:0], in_valid};
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_q[s]  <= rem_next[s];
      num_q[s]  <= num_next[s];
      quo_q[s]  <= quo_next[s];
      dv_q[s]   <= dv_in[s];
      meta_q[s] <= meta_in[s];
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quo       = quo_q[DIV_STAGES-1];
  assign meta      = meta_q[DIV_STAGES-1];

endmodule

// ----- design/i2cst_back.sv -----
// Back end: divider floor, rise time, field overflow checks and result register.
module i2cst_back import i2cst_pkg::*; #(
  parameter int DIV_WIDTH  = 12,
  parameter int RISE_WIDTH = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [QUO_W-1:0] quo,
  input  meta_t            meta,
  output logic             done,
  output rsp_t             result
);

  logic [QUO_W-1:0] ccr;
  logic [7:0]       rise;
  logic             zero_div;
  logic             ovf;
  logic [1:0]       status;
  rsp_t             res_next;

  // Finish the fields and decide the status
  always_comb begin
    if (meta.fast) begin
      ccr  = quo;
      rise = rise_fast(meta.mhz);
    end else begin
      ccr  = (quo < QUO_W'(4)) ? QUO_W'(4) : quo;
      rise = {2'b0, meta.mhz} + 8'd1;
    end
    zero_div = meta.fast && (quo == '0);
    ovf      = ((ccr >> DIV_WIDTH) != '0) || ((rise >> RISE_WIDTH) != '0);
    priority if (meta.status != ST_OK) begin
      status = meta.status;
    end else if (zero_div || ovf) begin
      status = ST_UNSUPPORTED;
    end else begin
      status = ST_OK;
    end

    res_next        = '0;
    res_next.status = status;
    if (status == ST_OK) begin
      res_next.ccr_value      = ccr[11:0];
      res_next.fast_mode      = meta.fast;
      res_next.duty_flag      = meta.dflag;
      res_next.rise_value     = rise[5:0];
      res_next.freq_mhz       = meta.mhz;
      res_next.addr_reg_value = {1'b1, 6'b0, meta.addr, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    result <= res_next;
  end

endmodule

// ----- design/i2c_scl_timing_calculator.sv -----
// Top level of the I2C SCL timing calculator: front end, divider pipeline, back end.
//
//   channel   ports                  direction  handshake
//   request   start, busy, request   in         taken when start high and busy low
//   result    done, result           out        one-cycle strobe, no back-pressure
//
// One item may enter every cycle; each taken item passes through 2 front stages,
// 13 divider stages at two quotient bits each and 1 output stage before its result.
// The divider pipeline holds most of these stages; throughput is one item per cycle.
// Reset is synchronous and clears all valid bits; busy is high only during reset.
// Nothing stalls: every stage advances each cycle and results are never held.
module i2c_scl_timing_calculator import i2cst_pkg::*; #(
  parameter int DIV_WIDTH  = 12,
  parameter int RISE_WIDTH = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  localparam int PIPE_LAT = FRONT_LAT + DIV_STAGES + 1;

  logic             take;
  logic             front_valid;
  div_in_t          front_item;
  logic             div_valid;
  logic [QUO_W-1:0] div_quo;
  meta_t            div_meta;

  assign busy = rst;
  assign take = start && !busy;

  i2cst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (take),
    .req       (request),
    .out_valid (front_valid),
    .div_in    (front_item)
  );

  i2cst_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_item   (front_item),
    .out_valid (div_valid),
    .quo       (div_quo),
    .meta      (div_meta)
  );

  i2cst_back #(
    .DIV_WIDTH  (DIV_WIDTH),
    .RISE_WIDTH (RISE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_valid),
    .quo      (div_quo),
    .meta     (div_meta),
    .done     (done),
    .result   (result)
  );

  // A result only ever follows an item taken a fixed latency earlier
  a_done_follows_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, PIPE_LAT))
    else $error("result strobe without a matching item");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK || result.status == ST_INVALID ||
              result.status == ST_UNSUPPORTED))
    else $error("undefined status code");

  a_fail_zeroed: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_OK) |->
      (result.ccr_value == '0) && (result.addr_reg_value == '0) &&
      (result.freq_mhz == '0) && !result.fast_mode)
    else $error("failed result carries nonzero fields");

  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ST_OK) |->
      result.addr_reg_value[14] && (result.freq_mhz >= 6'd2) &&
      (result.freq_mhz <= 6'd50))
    else $error("accepted result has bad address mark or clock");

  a_duty_needs_fast: assert property (@(posedge clk) disable iff (rst)
    done && result.duty_flag |-> result.fast_mode)
    else $error("duty flag set outside fast mode");

endmodule
